[rtl/crt_pkg.sv]
// Package: types and constants for the Garner CRT reconstruction block.
package crt_pkg;
  localparam int unsigned LimbCount = 4;
  localparam int unsigned ModWidth = 16;
  localparam int unsigned DigitCount = 2 * LimbCount;
  localparam int unsigned DigitIdxW = $clog2(DigitCount);
  localparam int unsigned LimbIdxW = $clog2(LimbCount);

  typedef struct packed {
    logic [15:0] residue;
    logic [15:0] modulus;
    logic        final_pair;
  } crt_in_t;

  typedef struct packed {
    logic [LimbIdxW-1:0] limb_index;
    logic [63:0]         limb_value;
    logic                overflow;
    logic                last_limb;
  } crt_out_t;

  // Shared modular unit commands.
  typedef enum logic [1:0] {
    MopMulMod = 2'd0,   // (a * b) mod m
    MopShiftMod = 2'd1  // ((a << 32) | b) mod m
  } crt_mop_e;

  typedef struct packed {
    logic        start;
    crt_mop_e    op;
    logic [31:0] a;
    logic [31:0] b;
    logic [ModWidth-1:0] m;
  } crt_mreq_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [ModWidth-1:0] r;
  } crt_mrsp_t;
endpackage

[rtl/crt_modunit.sv]
// Shared bit-serial modular reduction unit: one dividend bit per cycle.
module crt_modunit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crt_pkg::crt_mreq_t req_i,
  output crt_pkg::crt_mrsp_t rsp_o
);
  import crt_pkg::*;

  logic [63:0]         num_q, num_d;
  logic [ModWidth:0]   rem_q, rem_d;
  logic [ModWidth-1:0] m_q, m_d;
  logic [6:0]          cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [ModWidth+1:0] shl;
  logic [63:0]         prod;

  assign prod = 64'(req_i.a) * 64'(req_i.b);
  assign shl  = {rem_q, num_q[63]};

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    m_d = m_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      unique case (req_i.op)
        MopMulMod: num_d = prod;
        MopShiftMod: num_d = {req_i.a, req_i.b};
        default: num_d = prod;
      endcase
      rem_d = '0;
      m_d = req_i.m;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Restoring step: remainder stays below m, so one subtract suffices.
      if (shl >= {2'b00, m_q}) begin
        rem_d = (ModWidth+1)'(shl - {2'b00, m_q});
      end else begin
        rem_d = (ModWidth+1)'(shl);
      end
      rem_d[ModWidth] = 1'b0;
      num_d = {num_q[62:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    m_q <= m_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.r = rem_q[ModWidth-1:0];
endmodule

[rtl/crt_residue_to_binary.sv]
// Top level: Garner CRT reconstruction sequencer around a shared modular unit.
//
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i/in_stall_o  | crt_in_t  (residue, modulus, final_pair)
//  out     | out | out_valid_o/out_stall_i| crt_out_t (limb_index, value, flags)
//
// Each use of the shared modular unit runs issue, 64 remainder steps, then done.
// A pair uses it once for r mod m, 8 times each for X mod m and P mod m, up to 32 times
// for the Fermat inverse (a zero exponent bit skips its multiply) and once for k: up to
// 50 uses, plus 16 digit MAC steps.
// Reset clears X to zero, P to one and the overflow flag. A final pair emits
// four limbs; a stall on the output holds the current limb in place.
module crt_residue_to_binary (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  crt_pkg::crt_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output crt_pkg::crt_out_t  out_data_o
);
  import crt_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StRmod, StXmod, StPmod, StExp, StExpSq, StDiff, StK,
    StAdd, StScale, StEmit
  } st_e;

  st_e                   st_q;
  logic [63:0]           x_q [LimbCount];
  logic [63:0]           p_q [LimbCount];
  logic                  ovf_q;
  logic [ModWidth-1:0]   m_q, r_q, xm_q, a_q, acc_q, k_q;
  logic [ModWidth-1:0]   e_q;
  logic [15:0]           res_q;
  logic                  fin_q;
  logic [DigitIdxW:0]    idx_q;
  logic                  issued_q;
  logic [32:0]           carry_q;
  logic [LimbIdxW-1:0]   limb_q;
  crt_mreq_t             mreq;
  crt_mrsp_t             mrsp;

  crt_modunit u_mod (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  logic [DigitIdxW-1:0] di;
  logic [LimbIdxW-1:0]  dl;
  logic [31:0]          xd, pd;
  logic [63:0]          mac;
  assign di = idx_q[DigitIdxW-1:0];
  assign dl = di[DigitIdxW-1:1];
  assign xd = di[0] ? x_q[dl][63:32] : x_q[dl][31:0];
  assign pd = di[0] ? p_q[dl][63:32] : p_q[dl][31:0];
  // One digit MAC per cycle; result fits in 64 bits.
  assign mac = (st_q == StAdd) ? (64'(pd) * 64'(k_q) + 64'(xd) + 64'(carry_q))
                               : (64'(pd) * 64'(m_q) + 64'(carry_q));

  logic [31:0] digit_x, digit_p;
  assign digit_x = xd;
  assign digit_p = pd;

  always_comb begin
    mreq = '0;
    mreq.m = m_q;
    mreq.op = MopMulMod;
    unique case (st_q)
      StRmod: begin mreq.a = 32'(res_q); mreq.b = 32'd1; end
      StXmod: begin mreq.op = MopShiftMod; mreq.a = 32'(acc_q); mreq.b = digit_x; end
      StPmod: begin mreq.op = MopShiftMod; mreq.a = 32'(acc_q); mreq.b = digit_p; end
      StExp:  begin mreq.a = 32'(acc_q); mreq.b = 32'(a_q); end
      StExpSq: begin mreq.a = 32'(a_q); mreq.b = 32'(a_q); end
      StK:    begin mreq.a = 32'(k_q); mreq.b = 32'(acc_q); end
      default: ;
    endcase
    mreq.start = !issued_q && (st_q == StRmod || st_q == StXmod || st_q == StPmod
                 || (st_q == StExp && e_q[0]) || st_q == StExpSq || st_q == StK);
  end

  assign in_stall_o = (st_q != StIdle);
  assign out_valid_o = (st_q == StEmit);
  assign out_data_o.limb_index = limb_q;
  assign out_data_o.limb_value = x_q[limb_q];
  assign out_data_o.overflow = ovf_q;
  assign out_data_o.last_limb = (limb_q == LimbIdxW'(LimbCount - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      for (int i = 0; i < LimbCount; i++) begin
        x_q[i] <= '0;
        p_q[i] <= (i == 0) ? 64'd1 : 64'd0;
      end
      ovf_q <= 1'b0;
      issued_q <= 1'b0;
      idx_q <= '0;
      limb_q <= '0;
      fin_q <= 1'b0;
      m_q <= '0; r_q <= '0; xm_q <= '0; a_q <= '0; acc_q <= '0; k_q <= '0;
      e_q <= '0; res_q <= '0; carry_q <= '0;
    end else begin
      if (mreq.start) issued_q <= 1'b1;
      unique case (st_q)
        StIdle: begin
          if (in_valid_i) begin
            m_q <= in_data_i.modulus[ModWidth-1:0];
            res_q <= in_data_i.residue;
            fin_q <= in_data_i.final_pair;
            issued_q <= 1'b0;
            limb_q <= '0;
            if (in_data_i.modulus[ModWidth-1:0] >= ModWidth'(2)) begin
              st_q <= StRmod;
            end else if (in_data_i.final_pair) begin
              st_q <= StEmit;
            end
          end
        end
        StRmod: if (mrsp.done) begin
          r_q <= mrsp.r; acc_q <= '0; issued_q <= 1'b0;
          idx_q <= (DigitIdxW+1)'(DigitCount - 1); st_q <= StXmod;
        end
        StXmod: if (mrsp.done) begin
          issued_q <= 1'b0;
          if (idx_q == '0) begin
            xm_q <= mrsp.r; acc_q <= '0;
            idx_q <= (DigitIdxW+1)'(DigitCount - 1); st_q <= StPmod;
          end else begin
            acc_q <= mrsp.r;
            idx_q <= idx_q - (DigitIdxW+1)'(1);
          end
        end
        StPmod: if (mrsp.done) begin
          issued_q <= 1'b0;
          if (idx_q == '0) begin
            a_q <= mrsp.r;
            acc_q <= ModWidth'(1);
            e_q <= m_q - ModWidth'(2);
            idx_q <= '0;
            st_q <= StExp;
          end else begin
            acc_q <= mrsp.r;
            idx_q <= idx_q - (DigitIdxW+1)'(1);
          end
        end
        StExp: begin
          // Skip the multiply on a zero exponent bit.
          if (!e_q[0]) begin
            st_q <= StExpSq;
          end else if (mrsp.done) begin
            acc_q <= mrsp.r;
            issued_q <= 1'b0;
            st_q <= StExpSq;
          end
        end
        StExpSq: if (mrsp.done) begin
          a_q <= mrsp.r; issued_q <= 1'b0;
          e_q <= e_q >> 1;
          if (e_q[ModWidth-1:1] == '0) st_q <= StDiff;
          else st_q <= StExp;
        end
        StDiff: begin
          k_q <= (r_q >= xm_q) ? (r_q - xm_q) : (m_q - (xm_q - r_q));
          issued_q <= 1'b0;
          st_q <= StK;
        end
        StK: if (mrsp.done) begin
          k_q <= mrsp.r; carry_q <= '0; idx_q <= '0; st_q <= StAdd;
        end
        StAdd: begin
          if (di[0]) x_q[dl][63:32] <= mac[31:0];
          else x_q[dl][31:0] <= mac[31:0];
          if (idx_q == (DigitIdxW+1)'(DigitCount - 1)) begin
            if (mac[63:32] != '0) ovf_q <= 1'b1;
            carry_q <= '0; idx_q <= '0; st_q <= StScale;
          end else begin
            carry_q <= {1'b0, mac[63:32]};
            idx_q <= idx_q + (DigitIdxW+1)'(1);
          end
        end
        StScale: begin
          if (di[0]) p_q[dl][63:32] <= mac[31:0];
          else p_q[dl][31:0] <= mac[31:0];
          if (idx_q == (DigitIdxW+1)'(DigitCount - 1)) begin
            if (mac[63:32] != '0) ovf_q <= 1'b1;
            st_q <= fin_q ? StEmit : StIdle;
          end else begin
            carry_q <= {1'b0, mac[63:32]};
            idx_q <= idx_q + (DigitIdxW+1)'(1);
          end
        end
        StEmit: if (!out_stall_i) begin
          if (limb_q == LimbIdxW'(LimbCount - 1)) begin
            for (int i = 0; i < LimbCount; i++) begin
              x_q[i] <= '0;
              p_q[i] <= (i == 0) ? 64'd1 : 64'd0;
            end
            ovf_q <= 1'b0;
            st_q <= StIdle;
          end else limb_q <= limb_q + LimbIdxW'(1);
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench for crt_residue_to_binary: directed and random CRT runs checked limb by limb.

class crt_scoreboard;
  logic [255:0]            acc_value;
  logic [255:0]            mod_product;
  bit                      ovf_seen;
  crt_pkg::crt_out_t       limb_q[$];
  int unsigned             errors;
  int unsigned             limbs_checked;
  int unsigned             pairs_seen;
  int unsigned             runs_done;
  int unsigned             ovf_runs;

  function new();
    clear_run();
    errors = 0;
    limbs_checked = 0;
    pairs_seen = 0;
    runs_done = 0;
    ovf_runs = 0;
  endfunction

  function void clear_run();
    acc_value = '0;
    mod_product = 256'd1;
    ovf_seen = 1'b0;
  endfunction

  function longint unsigned fermat_inv(longint unsigned a, longint unsigned m);
    longint unsigned e;
    longint unsigned r;
    e = m - 2;
    r = 1 % m;
    for (int b = 0; b < crt_pkg::ModWidth; b++) begin
      if (e[b]) r = (r * a) % m;
      a = (a * a) % m;
    end
    return r;
  endfunction

  function longint unsigned wide_rem(logic [255:0] n, longint unsigned m);
    logic [255:0] t;
    t = n % {192'd0, m};
    return t[63:0];
  endfunction

  // Advance the predicted state by one accepted pair.
  function void note_pair(crt_pkg::crt_in_t item);
    longint unsigned m, r, pm, inv, xm, diff, k;
    logic [319:0] w;
    crt_pkg::crt_out_t o;
    pairs_seen++;
    m = 64'(item.modulus);
    if (m >= 2) begin
      r = 64'(item.residue) % m;
      pm = wide_rem(mod_product, m);
      inv = fermat_inv(pm, m);
      xm = wide_rem(acc_value, m);
      diff = (r >= xm) ? (r - xm) : (m - (xm - r));
      k = (diff * inv) % m;
      w = {64'd0, acc_value} + {64'd0, mod_product} * 320'(k);
      if (w[319:256] != 0) ovf_seen = 1'b1;
      acc_value = w[255:0];
      w = {64'd0, mod_product} * 320'(m);
      if (w[319:256] != 0) ovf_seen = 1'b1;
      mod_product = w[255:0];
    end
    if (item.final_pair) begin
      for (int i = 0; i < crt_pkg::LimbCount; i++) begin
        o.limb_index = i[1:0];
        o.limb_value = acc_value[64*i +: 64];
        o.overflow = ovf_seen;
        o.last_limb = (i == crt_pkg::LimbCount - 1);
        limb_q.push_back(o);
      end
      runs_done++;
      if (ovf_seen) ovf_runs++;
      clear_run();
    end
  endfunction

  task report(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  task check_limb(crt_pkg::crt_out_t got);
    crt_pkg::crt_out_t want;
    if (limb_q.size() == 0) begin
      report($sformatf("unexpected limb %0d value %h", got.limb_index, got.limb_value));
      return;
    end
    want = limb_q.pop_front();
    limbs_checked++;
    if (got.limb_index !== want.limb_index)
      report($sformatf("limb_index got %0d want %0d", got.limb_index, want.limb_index));
    if (got.limb_value !== want.limb_value)
      report($sformatf("limb %0d value got %h want %h", want.limb_index,
                       got.limb_value, want.limb_value));
    if (got.overflow !== want.overflow)
      report($sformatf("limb %0d overflow got %b want %b", want.limb_index,
                       got.overflow, want.overflow));
    if (got.last_limb !== want.last_limb)
      report($sformatf("limb %0d last_limb got %b want %b", want.limb_index,
                       got.last_limb, want.last_limb));
  endtask
endclass

module tb;
  import crt_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  crt_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  crt_out_t out_data;

  crt_scoreboard sb;
  crt_in_t       pair_q[$];
  bit            quiet_phase;   // no idling on either side near the end
  bit            hold_done;

  crt_residue_to_binary dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic bit is_prime(int unsigned v);
    if (v < 2) return 0;
    for (int unsigned d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 0;
    end
    return 1;
  endfunction

  // Pick a prime in [lo, hi] not yet used in the current run.
  function automatic int unsigned pick_prime(int unsigned lo, int unsigned hi,
                                             ref int unsigned used[$]);
    int unsigned v;
    bit dup;
    do begin
      v = $urandom_range(hi, lo);
      dup = 0;
      foreach (used[i]) if (used[i] == v) dup = 1;
    end while (!is_prime(v) || dup);
    used.push_back(v);
    return v;
  endfunction

  // Queue one well-formed run of n pairs with distinct primes.
  task automatic queue_run(int unsigned n, bit big);
    int unsigned used[$];
    crt_in_t p;
    for (int unsigned i = 0; i < n; i++) begin
      p.modulus = 16'(big ? pick_prime(40000, 65535, used)
                          : pick_prime(2, 65535, used));
      p.residue = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(65535, 0))
                                               : 16'($urandom_range(p.modulus - 1, 0));
      p.final_pair = (i == n - 1);
      pair_q.push_back(p);
    end
  endtask

  task automatic queue_pair(int unsigned r, int unsigned m, bit fin);
    crt_in_t p;
    p.residue = r[15:0];
    p.modulus = m[15:0];
    p.final_pair = fin;
    pair_q.push_back(p);
  endtask

  task automatic build_stimulus();
    // Directed: edge fields, degenerate moduli, then a run long enough to overflow.
    queue_pair(65535, 65521, 1'b1);  // residue above modulus, largest prime
    queue_pair(0, 2, 1'b1);          // smallest modulus
    queue_pair(65535, 0, 1'b1);      // modulus below two on a final pair
    queue_pair(7, 1, 1'b0);          // modulus below two, then a real pair
    queue_pair(65535, 65535, 1'b1);  // non-prime modulus
    queue_pair(12, 6, 1'b0);         // moduli sharing a factor
    queue_pair(9, 10, 1'b1);
    queue_run(18, 1'b1);             // product exceeds 256 bits
    // Random: mostly well-formed runs, some noise.
    while (pair_q.size() < 130) begin
      case ($urandom_range(9, 0))
        0: queue_pair($urandom_range(65535, 0), $urandom_range(1, 0),
                      1'($urandom_range(1, 0)));
        1: queue_pair($urandom_range(65535, 0), $urandom_range(65535, 2),
                      1'($urandom_range(1, 0)));
        2: queue_run($urandom_range(18, 16), 1'b1);
        default: queue_run($urandom_range(6, 1), 1'($urandom_range(1, 0)));
      endcase
    end
    // Close any run left open by noise.
    queue_run(1, 1'b0);
  endtask

  // Drive one pair and hold it until transferred.
  task automatic send_pair(crt_in_t p);
    if (!quiet_phase && $urandom_range(2, 0) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(9, 1)) @(negedge clk);
    end
    in_data = p;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_pair(p);
    @(negedge clk);
  endtask

  // Receiver: random stall bursts, one long hold-off to back up the block.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && sb.limbs_checked >= 6) begin
        hold_done = 1;
        out_stall = 1'b1;
        repeat (20000) @(negedge clk);
        out_stall = 1'b0;
      end else if (!quiet_phase && $urandom_range(3, 0) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(9, 1) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Check every transferred limb.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_limb(out_data);
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    sb = new();
    in_valid = 1'b0;
    in_data = '0;
    quiet_phase = 0;
    hold_done = 0;
    rst_n = 1'b0;
    build_stimulus();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    foreach (pair_q[i]) begin
      if (i >= pair_q.size() - 20) quiet_phase = 1;
      send_pair(pair_q[i]);
    end
    in_valid = 1'b0;
    // Drain outstanding limbs, then allow for in-flight work.
    while (sb.limb_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Covered %0d pairs in %0d reconstructions, %0d limbs checked.",
             sb.pairs_seen, sb.runs_done, sb.limbs_checked);
    $display("%0d reconstructions wrapped past 256 bits; %0d mismatches.",
             sb.ovf_runs, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[files.f]
rtl/crt_pkg.sv
rtl/crt_modunit.sv
rtl/crt_residue_to_binary.sv
dv/tb.sv
